// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL of the ordered-number block.
// Plain text only; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SPTON_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("spton: assertion failed");

// Next-cycle implication, disabled in reset.
`define SPTON_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("spton: assertion failed");

`endif

// ----- rtl/core/spton_pkg.sv -----
// Types and fixed constants of the string-to-ordered-number block.
// No dependencies; used by the stream interfaces and the top level.
package spton_pkg;

  typedef logic signed [7:0] char_t;
  typedef logic [63:0]       num_t;
  typedef logic [4:0]        plen_t;
  typedef logic [1:0]        reg_idx_t;

  // APB address width: three 32-bit registers at 0x0, 0x4, 0x8
  localparam int unsigned ADDR_W = 4;

  localparam reg_idx_t REG_LOWEST  = 2'd0;
  localparam reg_idx_t REG_HIGHEST = 2'd1;
  localparam reg_idx_t REG_PREFIX  = 2'd2;

  // Reset configuration: printable ASCII ' '..'~', nine-character prefix
  localparam char_t LOWEST_RST  = 8'sd32;
  localparam char_t HIGHEST_RST = 8'sd126;
  localparam plen_t PREFIX_RST  = 5'd9;

endpackage

// ----- rtl/core/spton_stream_if.sv -----
// Valid/ready stream interfaces: character beats in, number beats out.
// Depends on spton_pkg for the payload types.
interface spton_char_if;
  logic              valid;
  logic              ready;
  spton_pkg::char_t  character;
  logic              has_char;
  logic              last;

  modport source (output valid, character, has_char, last, input ready);
  modport sink   (input valid, character, has_char, last, output ready);
endinterface

interface spton_num_if;
  logic             valid;
  logic             ready;
  spton_pkg::num_t  number;

  modport source (output valid, number, input ready);
  modport sink   (input valid, number, output ready);
endinterface

// ----- rtl/core/string_prefix_to_ordered_number.sv -----
// Order-preserving 64-bit number of a character string, streamed one beat per char.
// Depends on spton_pkg, spton_stream_if.sv and assert_macros.svh.
//
// The block takes one character beat per clock, except while the weight table
// is rebuilt or a held result blocks a last beat, and returns, on the beat marked
// last, a 64-bit number whose order follows the string order over the configured
// alphabet and prefix. A beat passes the input register, the term register and
// the accumulate/result register before its result appears on num. The weight
// table is rebuilt by a sequencer after reset and after every APB write; during
// the rebuild chr.ready is low. The sequencer does one 64x8 multiply per entry.
// Registers: 0x0 lowest_char, 0x4 highest_char (signed bytes), 0x8 prefix_len.
`include "assert_macros.svh"

module string_prefix_to_ordered_number #(
  parameter int MAX_PREFIX = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  spton_char_if.sink                    chr,
  spton_num_if.source                   num,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [spton_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  // position counts up to MAX_PREFIX + 1 (one past the prefix marks "longer")
  localparam int POS_W = $clog2(MAX_PREFIX + 2);
  localparam int IDX_W = (MAX_PREFIX > 1) ? $clog2(MAX_PREFIX) : 1;
  localparam logic [POS_W-1:0] POS_SAT = POS_W'(MAX_PREFIX + 1);

  // table rebuild sequencer
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_INIT = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  // ---------------------------------------------------------------------------
  // Configuration registers (APB, zero wait state)
  // ---------------------------------------------------------------------------
  spton_pkg::char_t    lowest;
  spton_pkg::char_t    highest;
  spton_pkg::plen_t    prefix;
  spton_pkg::reg_idx_t cfg_idx;
  logic                cfg_we;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_we  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      lowest  <= spton_pkg::LOWEST_RST;
      highest <= spton_pkg::HIGHEST_RST;
      prefix  <= spton_pkg::PREFIX_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        spton_pkg::REG_LOWEST:  lowest  <= pwdata[7:0];
        spton_pkg::REG_HIGHEST: highest <= pwdata[7:0];
        spton_pkg::REG_PREFIX:  prefix  <= pwdata[4:0];
        default: ;  // unmapped: ignored
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      spton_pkg::REG_LOWEST:  prdata = {{24{lowest[7]}}, lowest};
      spton_pkg::REG_HIGHEST: prdata = {{24{highest[7]}}, highest};
      spton_pkg::REG_PREFIX:  prdata = {27'd0, prefix};
      default:                prdata = '0;
    endcase
  end

  // Effective prefix length, saturated to the table depth
  logic [POS_W-1:0] len;
  always_comb begin
    if (int'(prefix) > MAX_PREFIX) begin
      len = POS_W'(MAX_PREFIX);
    end else begin
      len = POS_W'(prefix);
    end
  end

  // Alphabet width, mod 256 (full byte range gives 0)
  logic [7:0] alpha_w;
  assign alpha_w = $unsigned(highest) - $unsigned(lowest) + 8'd1;

  // ---------------------------------------------------------------------------
  // Weight table rebuild: walk k = len-1 down to 0,
  //   sum += W^(len-1-k); weight[k] = sum; pw *= W
  // Entries at and above len stay cleared.
  // ---------------------------------------------------------------------------
  logic [1:0]        state;
  logic [POS_W-1:0]  cnt;
  logic [POS_W-1:0]  cnt_dec;
  spton_pkg::num_t   pw;
  spton_pkg::num_t   sum;
  spton_pkg::num_t   sum_next;
  spton_pkg::num_t   weights [MAX_PREFIX];

  assign sum_next = sum + pw;
  assign cnt_dec  = cnt - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else if (cfg_we) begin
      state <= ST_INIT;
    end else begin
      unique case (state)
        ST_INIT: state <= ST_RUN;
        ST_RUN:  if (cnt == '0) state <= ST_IDLE;
        ST_IDLE: ;
        default: state <= ST_INIT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_INIT) begin
      cnt <= len;
      pw  <= 64'd1;
      sum <= '0;
      for (int i = 0; i < MAX_PREFIX; i++) begin
        weights[i] <= '0;
      end
    end else if (state == ST_RUN && cnt != '0) begin
      weights[cnt_dec[IDX_W-1:0]] <= sum_next;
      sum <= sum_next;
      pw  <= pw * {56'd0, alpha_w};
      cnt <= cnt_dec;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input register
  // ---------------------------------------------------------------------------
  logic             v1;
  spton_pkg::char_t ch1;
  logic             hc1;
  logic             last1;
  logic             adv2;
  logic             in_acc;

  assign chr.ready = (state == ST_IDLE) & (~v1 | adv2);
  assign in_acc    = chr.valid & chr.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_acc) begin
      v1 <= 1'b1;
    end else if (adv2) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch1   <= chr.character;
      hc1   <= chr.has_char;
      last1 <= chr.last;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 logic: clamp, digit, table read, digit * weight + 1
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   pos_inc;
  spton_pkg::char_t   clamped;
  logic [8:0]         diff;
  logic [7:0]         mag;
  spton_pkg::num_t    weight;
  spton_pkg::num_t    prod;
  spton_pkg::num_t    term;
  logic               contrib;
  logic               extra;

  always_comb begin
    clamped = ch1;
    if (clamped < lowest) clamped = lowest;
    if (clamped > highest) clamped = highest;
  end

  // negative only for an inverted range; product taken mod 2^64
  assign diff    = {clamped[7], clamped} - {lowest[7], lowest};
  assign mag     = diff[8] ? 8'(~diff + 9'd1) : diff[7:0];
  assign weight  = weights[pos[IDX_W-1:0]];
  assign prod    = weight * {56'd0, mag};
  assign term    = diff[8] ? (64'd1 - prod) : (prod + 64'd1);
  assign contrib = hc1 & (pos < len);
  assign pos_inc = (hc1 && pos != POS_SAT) ? pos + 1'b1 : pos;
  assign extra   = pos_inc > len;

  // ---------------------------------------------------------------------------
  // Stage 2: term register; stage 3: accumulator and result register
  // ---------------------------------------------------------------------------
  logic             v2;
  spton_pkg::num_t  term2;
  logic             last2;
  logic             extra2;
  logic             fire2;
  spton_pkg::num_t  acc;
  spton_pkg::num_t  rnum;
  logic             rv;

  // a last beat waits only while the result register is still held
  assign fire2 = v2 & ~(last2 & rv & ~num.ready);
  assign adv2  = ~v2 | fire2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2  <= 1'b0;
      pos <= '0;
    end else if (adv2) begin
      v2 <= v1;
      if (v1) begin
        pos <= last1 ? '0 : pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      term2  <= contrib ? term : '0;
      last2  <= last1;
      extra2 <= extra;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      rv  <= 1'b0;
    end else begin
      if (fire2) begin
        acc <= last2 ? '0 : acc + term2;
      end
      if (fire2 && last2) begin
        rv <= 1'b1;
      end else if (num.ready) begin
        rv <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire2 && last2) begin
      rnum <= acc + term2 + 64'(extra2);
    end
  end

  assign num.valid  = rv;
  assign num.number = rnum;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `SPTON_ASSERT_NEXT(a_cfg_write_stalls_input, clk, rst, cfg_we, !chr.ready)
  `SPTON_ASSERT_IMPL(a_rebuild_count_in_range, clk, rst, state == ST_RUN, cnt <= len)
  `SPTON_ASSERT_NEXT(a_last_beat_gives_result, clk, rst, fire2 && last2, rv && acc == '0)
  `SPTON_ASSERT_IMPL(a_position_saturates, clk, rst, v1 || v2, pos <= POS_SAT)

endmodule
